// File: design/assert_macros.svh
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CAH_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define CAH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: design/cah_pkg.sv
// Types, constants and helper functions of the chord angle histogram
package cah_pkg;

  // widest bin address over the parameter range (1024 x 1024 bins)
  localparam int ADDR_MAX_W = 20;

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } cah_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } cah_state_e;

  localparam logic [2:0] REG_MIN_LEN     = 3'd0;
  localparam logic [2:0] REG_MAX_LEN     = 3'd1;
  localparam logic [2:0] REG_MIN_ANGLE   = 3'd2;
  localparam logic [2:0] REG_MAX_ANGLE   = 3'd3;
  localparam logic [2:0] REG_LEN_SCALE   = 3'd4;
  localparam logic [2:0] REG_ANGLE_SCALE = 3'd5;
  localparam logic [2:0] REG_MAP_ROWS    = 3'd6;
  localparam logic [2:0] REG_MAP_COLS    = 3'd7;

  typedef struct packed {
    logic [31:0]        min_len;
    logic [31:0]        max_len;
    logic signed [31:0] min_angle;
    logic signed [31:0] max_angle;
    logic [31:0]        len_scale;
    logic [31:0]        angle_scale;
    logic [6:0]         map_rows;
    logic [6:0]         map_cols;
  } cah_cfg_t;

  localparam cah_cfg_t CFG_RESET = '{
    min_len:     32'd0,
    max_len:     32'd6553600,
    min_angle:   -32'sd102944,
    max_angle:   32'sd102944,
    len_scale:   32'd41288,
    angle_scale: 32'd1314226,
    map_rows:    7'd64,
    map_cols:    7'd64
  };

  typedef struct packed {
    cah_op_e            op;
    logic [31:0]        void_length;
    logic [31:0]        solid_length;
    logic signed [31:0] walk_angle;
    logic [11:0]        bin_index;
  } cah_in_t;

  typedef struct packed {
    logic [5:0]  void_row;
    logic [5:0]  solid_row;
    logic [5:0]  angle_col;
    logic        solid_counted;
    logic [31:0] void_count;
    logic [31:0] solid_count;
  } cah_out_t;

  // classified item handed from the front end to the update engine
  typedef struct packed {
    cah_op_e               op;
    logic                  hit;    // read: bin inside the map
    logic                  s_en;   // record: solid bin is counted
    logic [ADDR_MAX_W-1:0] v_addr;
    logic [ADDR_MAX_W-1:0] s_addr;
    logic [5:0]            void_row;
    logic [5:0]            solid_row;
    logic [5:0]            angle_col;
  } cah_item_t;

  // clamp to [lo, hi] and remove lo; an inverted range gives zero
  function automatic logic [31:0] len_offset(input logic [31:0] v, input logic [31:0] lo,
                                             input logic [31:0] hi);
    logic [31:0] c;
    c = (v < lo) ? lo : v;
    c = (c > hi) ? hi : c;
    return (c < lo) ? 32'd0 : (c - lo);
  endfunction

  function automatic logic [31:0] angle_offset(input logic signed [31:0] a,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
    logic signed [31:0] c;
    logic signed [32:0] d;
    c = (a < lo) ? lo : a;
    c = (c > hi) ? hi : c;
    d = $signed({c[31], c}) - $signed({lo[31], lo});
    return (c < lo) ? 32'd0 : d[31:0];
  endfunction

endpackage

// File: design/chord_angle_histogram_2d.sv
// Top level of the two-map chord length by angle histogram
//
// Input channel (in_valid_i / in_ready_o / in_data_i): op OP_RECORD bins a
// sample into the void map and, for a nonzero solid length, the solid map;
// op OP_READ returns both counts at bin_index. Every item gives one result on
// the output channel (out_valid_o / out_ready_i / out_data_o), in order.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write them only while no item is in flight,
// as the block does not enforce it. An item passes the front end, the queue,
// the update engine and the output register; the engine does the
// read-modify-write of the count RAMs for one item before it takes the next.
// The front end (two stages) feeds a two-entry queue, so inputs keep flowing
// while the update engine or the output side stalls; a result waiting in the
// output register blocks further updates, and input transfers go on until the
// front end and the queue have filled.
// After reset both maps are swept to zero, one bin a cycle, over all
// MAP_ROWS * MAP_COLS bins (4096 by default); in_ready_o stays low meanwhile.
`include "assert_macros.svh"

module chord_angle_histogram_2d #(
  parameter int MAP_ROWS    = 64,
  parameter int MAP_COLS    = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cah_pkg::cah_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cah_pkg::cah_out_t out_data_o
);

  cah_pkg::cah_cfg_t  cfg_q;
  cah_pkg::cah_item_t f_item, q_item;
  logic               f_valid, q_full, q_empty, q_push, q_pop, clear_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cah_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cah_pkg::REG_MIN_LEN:     cfg_q.min_len     <= cfg_wdata_i;
        cah_pkg::REG_MAX_LEN:     cfg_q.max_len     <= cfg_wdata_i;
        cah_pkg::REG_MIN_ANGLE:   cfg_q.min_angle   <= $signed(cfg_wdata_i);
        cah_pkg::REG_MAX_ANGLE:   cfg_q.max_angle   <= $signed(cfg_wdata_i);
        cah_pkg::REG_LEN_SCALE:   cfg_q.len_scale   <= cfg_wdata_i;
        cah_pkg::REG_ANGLE_SCALE: cfg_q.angle_scale <= cfg_wdata_i;
        cah_pkg::REG_MAP_ROWS:    cfg_q.map_rows    <= cfg_wdata_i[6:0];
        cah_pkg::REG_MAP_COLS:    cfg_q.map_cols    <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  cah_front #(.MAP_ROWS(MAP_ROWS), .MAP_COLS(MAP_COLS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .hold_i      (clear_busy),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .item_valid_o(f_valid),
    .item_ready_i(!q_full),
    .item_o      (f_item)
  );

  assign q_push = f_valid && !q_full;

  cah_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (f_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_item)
  );

  cah_back #(.DEPTH(MAP_ROWS * MAP_COLS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_busy_o(clear_busy),
    .item_valid_i(!q_empty),
    .item_i      (q_item),
    .item_pop_o  (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // the clearing sweep runs once per reset
  `CAH_ASSERT_NEXT(a_clear_once, !clear_busy, !clear_busy, "clearing sweep restarted")

  // an item leaves the queue only when its result has somewhere to go
  `CAH_ASSERT_IMPL(a_pop_room, q_pop, !out_valid_o || out_ready_i, "pop with output blocked")

  // a record result with the solid bin counted never carries counts
  `CAH_ASSERT_IMPL(a_record_no_count, out_valid_o && out_data_o.solid_counted,
                   out_data_o.void_count == 32'd0 && out_data_o.solid_count == 32'd0,
                   "record result with counts")

endmodule

// File: design/cah_ram.sv
// Generic single-write, single-read RAM with registered read data
module cah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cah_front.sv
// Front end: clamps, scales and turns each item into bin addresses
module cah_front #(
  parameter int MAP_ROWS = 64,
  parameter int MAP_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cah_pkg::cah_cfg_t cfg_i,
  input  logic              hold_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cah_pkg::cah_in_t  in_data_i,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output cah_pkg::cah_item_t item_o
);

  localparam int RW    = $clog2(MAP_ROWS);
  localparam int CW    = $clog2(MAP_COLS);
  localparam int RCW   = $clog2(MAP_ROWS + 1);
  localparam int CCW   = $clog2(MAP_COLS + 1);
  localparam int DEPTH = MAP_ROWS * MAP_COLS;

  logic adv;

  // stage 1: offsets
  logic             s1_valid_q;
  cah_pkg::cah_op_e s1_op_q;
  logic [11:0]      s1_bin_q;
  logic             s1_snz_q;
  logic [31:0]      s1_voff_q, s1_soff_q, s1_aoff_q;
  logic [31:0]      s1_voff_d, s1_soff_d, s1_aoff_d;

  // stage 2: products
  logic             s2_valid_q;
  cah_pkg::cah_op_e s2_op_q;
  logic [11:0]      s2_bin_q;
  logic             s2_snz_q;
  logic [63:0]      s2_vprod_q, s2_sprod_q, s2_aprod_q;

  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;
  logic [RW-1:0]  last_row, vrow, srow;
  logic [CW-1:0]  last_col, col;
  logic [31:0]    vi, si, ai;
  logic [31:0]    vaddr_w, saddr_w, vrow_w, srow_w, col_w;

  assign adv          = !s2_valid_q || item_ready_i;
  assign in_ready_o   = adv && !hold_i;
  assign item_valid_o = s2_valid_q;

  assign s1_voff_d = cah_pkg::len_offset(in_data_i.void_length, cfg_i.min_len, cfg_i.max_len);
  assign s1_soff_d = cah_pkg::len_offset(in_data_i.solid_length, cfg_i.min_len, cfg_i.max_len);
  assign s1_aoff_d = cah_pkg::angle_offset(in_data_i.walk_angle, cfg_i.min_angle,
                                           cfg_i.max_angle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i && !hold_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= in_data_i.op;
      s1_bin_q   <= in_data_i.bin_index;
      s1_snz_q   <= (in_data_i.solid_length != 32'd0);
      s1_voff_q  <= s1_voff_d;
      s1_soff_q  <= s1_soff_d;
      s1_aoff_q  <= s1_aoff_d;
      s2_op_q    <= s1_op_q;
      s2_bin_q   <= s1_bin_q;
      s2_snz_q   <= s1_snz_q;
      s2_vprod_q <= 64'(s1_voff_q) * 64'(cfg_i.len_scale);
      s2_sprod_q <= 64'(s1_soff_q) * 64'(cfg_i.len_scale);
      s2_aprod_q <= 64'(s1_aoff_q) * 64'(cfg_i.angle_scale);
    end
  end

  // rows and columns in use, limited to 1 .. parameter
  always_comb begin
    if (cfg_i.map_rows == 7'd0) begin
      rows_eff = RCW'(1);
    end else if (32'(cfg_i.map_rows) > 32'(MAP_ROWS)) begin
      rows_eff = RCW'(MAP_ROWS);
    end else begin
      rows_eff = RCW'(cfg_i.map_rows);
    end
    if (cfg_i.map_cols == 7'd0) begin
      cols_eff = CCW'(1);
    end else if (32'(cfg_i.map_cols) > 32'(MAP_COLS)) begin
      cols_eff = CCW'(MAP_COLS);
    end else begin
      cols_eff = CCW'(cfg_i.map_cols);
    end
  end

  assign last_row = RW'(rows_eff - RCW'(1));
  assign last_col = CW'(cols_eff - CCW'(1));

  // integer part of the Q32.32 product, saturated at the last bin
  assign vi   = s2_vprod_q[63:32];
  assign si   = s2_sprod_q[63:32];
  assign ai   = s2_aprod_q[63:32];
  assign vrow = (vi > 32'(last_row)) ? last_row : vi[RW-1:0];
  assign srow = (si > 32'(last_row)) ? last_row : si[RW-1:0];
  assign col  = (ai > 32'(last_col)) ? last_col : ai[CW-1:0];

  assign vaddr_w = 32'(vrow) * 32'(cols_eff) + 32'(col);
  assign saddr_w = 32'(srow) * 32'(cols_eff) + 32'(col);
  assign vrow_w  = 32'(vrow);
  assign srow_w  = 32'(srow);
  assign col_w   = 32'(col);

  always_comb begin
    item_o    = '0;
    item_o.op = s2_op_q;
    if (s2_op_q == cah_pkg::OP_READ) begin
      item_o.hit    = (32'(s2_bin_q) < 32'(DEPTH));
      item_o.v_addr = cah_pkg::ADDR_MAX_W'(s2_bin_q);
      item_o.s_addr = cah_pkg::ADDR_MAX_W'(s2_bin_q);
    end else begin
      item_o.hit       = 1'b1;
      item_o.s_en      = s2_snz_q;
      item_o.v_addr    = vaddr_w[cah_pkg::ADDR_MAX_W-1:0];
      item_o.s_addr    = saddr_w[cah_pkg::ADDR_MAX_W-1:0];
      item_o.void_row  = vrow_w[5:0];
      item_o.solid_row = srow_w[5:0];
      item_o.angle_col = col_w[5:0];
    end
  end

endmodule

// File: design/cah_queue.sv
// Two-entry queue between the front end and the update engine
module cah_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cah_pkg::cah_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output cah_pkg::cah_item_t data_o
);

  cah_pkg::cah_item_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/cah_back.sv
// Update engine: clears maps, then reads each item and updates records
module cah_back #(
  parameter int DEPTH       = 4096,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               clear_busy_o,
  input  logic               item_valid_i,
  input  cah_pkg::cah_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cah_pkg::cah_out_t  out_data_o
);

  localparam int AW = $clog2(DEPTH);

  cah_pkg::cah_state_e state_q, state_d;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  cah_pkg::cah_item_t  cur_q;
  logic                out_valid_q;
  cah_pkg::cah_out_t   out_q, out_d;
  logic                take;

  logic                   we_v, we_s, re;
  logic [AW-1:0]          waddr_v, waddr_s, raddr_v, raddr_s;
  logic [COUNT_WIDTH-1:0] wdata_v, wdata_s, rd_v, rd_s;
  logic [63:0]            rd_v_ext, rd_s_ext;

  cah_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_void_ram (
    .clk_i  (clk_i),
    .we_i   (we_v),
    .waddr_i(waddr_v),
    .wdata_i(wdata_v),
    .re_i   (re),
    .raddr_i(raddr_v),
    .rdata_o(rd_v)
  );

  cah_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_solid_ram (
    .clk_i  (clk_i),
    .we_i   (we_s),
    .waddr_i(waddr_s),
    .wdata_i(wdata_s),
    .re_i   (re),
    .raddr_i(raddr_s),
    .rdata_o(rd_s)
  );

  // the output register is free by the time the update cycle loads it
  assign take = item_valid_i && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      cah_pkg::ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = cah_pkg::ST_IDLE;
        end
      end
      cah_pkg::ST_IDLE: begin
        if (take) begin
          state_d = cah_pkg::ST_UPDATE;
        end
      end
      cah_pkg::ST_UPDATE: begin
        state_d = cah_pkg::ST_IDLE;
      end
      default: begin
        state_d = cah_pkg::ST_CLEAR;
      end
    endcase
  end

  // RAM and queue controls
  always_comb begin
    we_v         = 1'b0;
    we_s         = 1'b0;
    re           = 1'b0;
    item_pop_o   = 1'b0;
    clear_busy_o = 1'b0;
    waddr_v      = cur_q.v_addr[AW-1:0];
    waddr_s      = cur_q.s_addr[AW-1:0];
    wdata_v      = rd_v + COUNT_WIDTH'(1);
    wdata_s      = rd_s + COUNT_WIDTH'(1);
    raddr_v      = item_i.v_addr[AW-1:0];
    raddr_s      = item_i.s_addr[AW-1:0];
    unique case (state_q)
      cah_pkg::ST_CLEAR: begin
        clear_busy_o = 1'b1;
        we_v         = 1'b1;
        we_s         = 1'b1;
        waddr_v      = clr_addr_q;
        waddr_s      = clr_addr_q;
        wdata_v      = '0;
        wdata_s      = '0;
      end
      cah_pkg::ST_IDLE: begin
        re         = take;
        item_pop_o = take;
      end
      cah_pkg::ST_UPDATE: begin
        we_v = (cur_q.op == cah_pkg::OP_RECORD);
        we_s = (cur_q.op == cah_pkg::OP_RECORD) && cur_q.s_en;
      end
      default: begin
        clear_busy_o = 1'b1;
      end
    endcase
  end

  assign rd_v_ext = 64'(rd_v);
  assign rd_s_ext = 64'(rd_s);

  always_comb begin
    out_d               = '0;
    out_d.void_row      = cur_q.void_row;
    out_d.solid_row     = cur_q.solid_row;
    out_d.angle_col     = cur_q.angle_col;
    out_d.solid_counted = (cur_q.op == cah_pkg::OP_RECORD) && cur_q.s_en;
    if (cur_q.op == cah_pkg::OP_READ && cur_q.hit) begin
      out_d.void_count  = rd_v_ext[31:0];
      out_d.solid_count = rd_s_ext[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cah_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      if (state_q == cah_pkg::ST_UPDATE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && state_q == cah_pkg::ST_IDLE) begin
      cur_q <= item_i;
    end
    if (state_q == cah_pkg::ST_UPDATE) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
